>>> rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// Each macro expects signals named clk and rst_n in the scope of its use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define COAPD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Condition in one cycle implies a condition in the next.
`define COAPD_ASSERT_NEXT(label, pre, post, msg) \
  `COAPD_ASSERT(label, (pre) |=> (post), msg)

`endif

>>> rtl/coapd_pkg.sv
// Package for the CoAP message decoder: phase, kind and status codes,
// decoder state and result types. No dependencies.
package coapd_pkg;

  // Decoder phases
  localparam logic [3:0] PH_HDR     = 4'd0;
  localparam logic [3:0] PH_TOKEN   = 4'd1;
  localparam logic [3:0] PH_OPT     = 4'd2;
  localparam logic [3:0] PH_D1      = 4'd3;
  localparam logic [3:0] PH_D2H     = 4'd4;
  localparam logic [3:0] PH_D2L     = 4'd5;
  localparam logic [3:0] PH_L1      = 4'd6;
  localparam logic [3:0] PH_L2H     = 4'd7;
  localparam logic [3:0] PH_L2L     = 4'd8;
  localparam logic [3:0] PH_VALUE   = 4'd9;
  localparam logic [3:0] PH_PAYLOAD = 4'd10;
  localparam logic [3:0] PH_ERROR   = 4'd11;

  // Result kinds
  localparam logic [3:0] KIND_HEADER    = 4'd0;
  localparam logic [3:0] KIND_HDR_DONE  = 4'd1;
  localparam logic [3:0] KIND_TOKEN     = 4'd2;
  localparam logic [3:0] KIND_OPT_HDR   = 4'd3;
  localparam logic [3:0] KIND_OPT_START = 4'd4;
  localparam logic [3:0] KIND_OPT_VALUE = 4'd5;
  localparam logic [3:0] KIND_MARKER    = 4'd6;
  localparam logic [3:0] KIND_PAYLOAD   = 4'd7;
  localparam logic [3:0] KIND_IGNORED   = 4'd8;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_DELTA = 3'd1;
  localparam logic [2:0] ST_BAD_LEN   = 3'd2;
  localparam logic [2:0] ST_TRUNC     = 3'd3;
  localparam logic [2:0] ST_OVERFLOW  = 3'd4;

  localparam logic [7:0]  PAYLOAD_MARKER = 8'hff;
  localparam logic [3:0]  NIB_EXT1       = 4'd13;
  localparam logic [3:0]  NIB_EXT2       = 4'd14;
  localparam logic [3:0]  NIB_BAD        = 4'd15;
  localparam logic [16:0] EXT1_BIAS      = 17'd13;
  localparam logic [16:0] EXT2_BIAS      = 17'd269;

  typedef struct packed {
    logic [3:0]  phase;
    logic [3:0]  byte_count;
    logic [1:0]  header_type;
    logic [7:0]  header_code;
    logic [15:0] header_id;
    logic [3:0]  token_len;
    logic [15:0] option_accum;
    logic [7:0]  delta_hi;       // high byte of a two-byte delta extension
    logic [7:0]  length_hi;      // high byte of a two-byte length extension
    logic [3:0]  length_nibble;
    logic [16:0] value_remaining;
    logic [2:0]  error_code;
  } state_t;

  localparam state_t STATE_RESET = state_t'('0);

  typedef struct packed {
    logic [3:0]  kind;
    logic [1:0]  msg_type;
    logic [7:0]  msg_code;
    logic [15:0] msg_id;
    logic [3:0]  token_len;
    logic [15:0] option_number;
    logic [16:0] option_length;
    logic [7:0]  data_byte;
    logic        end_of_message;
    logic [2:0]  status;
  } result_t;

endpackage

>>> rtl/coapd_if.sv
// Channel interfaces of the CoAP message decoder: raw byte input and
// classified result output. No dependencies.
interface coapd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_last;

  modport source(output valid, output in_byte, output is_last, input ready);
  modport sink(input valid, input in_byte, input is_last, output ready);
endinterface

interface coapd_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kind;
  logic [1:0]  msg_type;
  logic [7:0]  msg_code;
  logic [15:0] msg_id;
  logic [3:0]  token_len;
  logic [15:0] option_number;
  logic [16:0] option_length;
  logic [7:0]  data_byte;
  logic        end_of_message;
  logic [2:0]  status;

  modport source(output valid, output kind, output msg_type, output msg_code,
                 output msg_id, output token_len, output option_number,
                 output option_length, output data_byte, output end_of_message,
                 output status, input ready);
  modport sink(input valid, input kind, input msg_type, input msg_code,
               input msg_id, input token_len, input option_number,
               input option_length, input data_byte, input end_of_message,
               input status, output ready);
endinterface

>>> rtl/coapd_step.sv
// Per-byte decode step: next decoder state and result for one byte.
// Depends on coapd_pkg.
module coapd_step (
  input  coapd_pkg::state_t  st,
  input  logic [7:0]         din,
  input  logic               last,
  output coapd_pkg::state_t  st_nxt,
  output coapd_pkg::result_t res
);
  import coapd_pkg::*;

  state_t      nx;
  logic [3:0]  dn;
  logic [3:0]  ln;
  logic [3:0]  cnt_inc;
  logic [16:0] d_val;
  logic [17:0] sum;
  logic [16:0] olen;
  logic        do_delta;
  logic        do_start;
  logic [3:0]  kind;
  logic [15:0] num;
  logic [16:0] len;
  logic [7:0]  data;

  assign dn      = din[7:4];
  assign ln      = din[3:0];
  assign cnt_inc = st.byte_count + 4'd1;

  // Delta candidate for the phase that completes it
  always_comb begin
    if (st.phase == PH_D1) begin
      d_val = {9'd0, din} + EXT1_BIAS;
    end else if (st.phase == PH_D2L) begin
      d_val = {1'b0, st.delta_hi, din} + EXT2_BIAS;
    end else begin
      d_val = {13'd0, dn};
    end
  end

  assign sum = {2'b00, st.option_accum} + {1'b0, d_val};

  always_comb begin
    nx       = st;
    kind     = KIND_IGNORED;
    num      = '0;
    len      = '0;
    data     = '0;
    do_delta = 1'b0;
    do_start = 1'b0;
    olen     = '0;

    unique case (st.phase)
      PH_HDR: begin
        if (st.byte_count == 4'd0) begin
          nx.header_type = din[5:4];
          nx.token_len   = din[3:0];
        end else if (st.byte_count == 4'd1) begin
          nx.header_code = din;
        end else if (st.byte_count == 4'd2) begin
          nx.header_id = {din, 8'h00};
        end else begin
          nx.header_id = {st.header_id[15:8], din};
        end
        if (st.byte_count >= 4'd3) begin
          kind          = KIND_HDR_DONE;
          nx.byte_count = '0;
          nx.phase      = (nx.token_len != 4'd0) ? PH_TOKEN : PH_OPT;
        end else begin
          kind          = KIND_HEADER;
          nx.byte_count = cnt_inc;
        end
      end
      PH_TOKEN: begin
        kind = KIND_TOKEN;
        data = din;
        if (cnt_inc >= st.token_len) begin
          nx.byte_count = '0;
          nx.phase      = PH_OPT;
        end else begin
          nx.byte_count = cnt_inc;
        end
      end
      PH_OPT: begin
        if (din == PAYLOAD_MARKER) begin
          kind     = KIND_MARKER;
          nx.phase = PH_PAYLOAD;
        end else begin
          kind = KIND_OPT_HDR;
          if (dn == NIB_BAD) begin
            nx.error_code = ST_BAD_DELTA;
            nx.phase      = PH_ERROR;
          end else if (ln == NIB_BAD) begin
            nx.error_code = ST_BAD_LEN;
            nx.phase      = PH_ERROR;
          end else begin
            nx.length_nibble = ln;
            if (dn == NIB_EXT1) begin
              nx.phase = PH_D1;
            end else if (dn == NIB_EXT2) begin
              nx.phase = PH_D2H;
            end else begin
              do_delta = 1'b1;
            end
          end
        end
      end
      PH_D1, PH_D2L: begin
        do_delta = 1'b1;
      end
      PH_D2H: begin
        kind        = KIND_OPT_HDR;
        nx.delta_hi = din;
        nx.phase    = PH_D2L;
      end
      PH_L1: begin
        do_start = 1'b1;
        olen     = {9'd0, din} + EXT1_BIAS;
      end
      PH_L2H: begin
        kind         = KIND_OPT_HDR;
        nx.length_hi = din;
        nx.phase     = PH_L2L;
      end
      PH_L2L: begin
        do_start = 1'b1;
        olen     = {1'b0, st.length_hi, din} + EXT2_BIAS;
      end
      PH_VALUE: begin
        kind = KIND_OPT_VALUE;
        data = din;
        if (st.value_remaining != '0) begin
          nx.value_remaining = st.value_remaining - 17'd1;
        end
        if (nx.value_remaining == '0) begin
          nx.phase = PH_OPT;
        end
      end
      PH_PAYLOAD: begin
        kind = KIND_PAYLOAD;
        data = din;
      end
      default: begin
        kind = KIND_IGNORED;
      end
    endcase

    // Complete a delta: add to the running number, then go on to the length
    if (do_delta) begin
      kind = KIND_OPT_HDR;
      if (sum[17:16] != 2'b00) begin
        nx.error_code = ST_OVERFLOW;
        nx.phase      = PH_ERROR;
      end else begin
        nx.option_accum = sum[15:0];
        if (nx.length_nibble == NIB_EXT1) begin
          nx.phase = PH_L1;
        end else if (nx.length_nibble == NIB_EXT2) begin
          nx.phase = PH_L2H;
        end else begin
          do_start = 1'b1;
          olen     = {13'd0, nx.length_nibble};
        end
      end
    end

    // Option header complete: report number and length
    if (do_start) begin
      kind               = KIND_OPT_START;
      num                = nx.option_accum;
      len                = olen;
      nx.value_remaining = olen;
      nx.phase           = (olen != '0) ? PH_VALUE : PH_OPT;
    end

    // Message ends mid-element
    if (last && nx.error_code == ST_OK && nx.phase != PH_OPT &&
        nx.phase != PH_PAYLOAD) begin
      nx.error_code = ST_TRUNC;
    end

    res.kind           = kind;
    res.msg_type       = nx.header_type;
    res.msg_code       = nx.header_code;
    res.msg_id         = nx.header_id;
    res.token_len      = nx.token_len;
    res.option_number  = num;
    res.option_length  = len;
    res.data_byte      = data;
    res.end_of_message = last;
    res.status         = nx.error_code;

    st_nxt = last ? STATE_RESET : nx;
  end

endmodule

>>> rtl/coap_message_decoder.sv
// CoAP message decoder (RFC 7252 framing), byte serial, one classified
// result item for every input item. One byte is accepted per clock cycle
// when the result side keeps up: a byte is first held in an input register,
// then classified by the combinational decode step against the decoder state,
// and the result lands in an output register, from which it is offered.
// The decode step (phase, counters and the 16-bit option number add) is
// combinational, which sets the rate of one item per cycle while the result
// side keeps up. The input side keeps accepting while a finished result
// waits, as long as the input register is free or moves on in that cycle.
// After the item flagged as the last byte of a message, all decoder state
// returns to its reset value, ready for the next message. Errors (bad
// nibble, option number overflow) mark the rest of the message as ignored;
// a message cut short inside the header, token or an option reports a
// truncated status on its last result. Depends on coapd_pkg and the
// interfaces in coapd_if.
module coap_message_decoder (
  input logic         clk,
  input logic         rst_n,
  coapd_in_if.sink    in_ch,
  coapd_out_if.source out_ch
);
  import coapd_pkg::*;

  // Input register
  logic       s1_valid_r;
  logic       s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // Decoder state and result register
  state_t     state_r;
  state_t     state_nxt;
  result_t    res_nxt;
  result_t    out_res_r;
  logic       out_valid_r;
  logic       out_valid_nxt;

  logic       out_free;
  logic       s1_adv;
  logic       in_acc;

  // Output register can take a new result when empty or being drained
  assign out_free = !out_valid_r || out_ch.ready;
  // Advance the held byte through the decode step into the output register
  assign s1_adv   = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign in_acc   = in_ch.valid && in_ch.ready;

  coapd_step u_step (
    .st     (state_r),
    .din    (s1_byte_r),
    .last   (s1_last_r),
    .st_nxt (state_nxt),
    .res    (res_nxt)
  );

  always_comb begin
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_comb begin
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= STATE_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        state_r <= state_nxt;
      end
    end
  end

  // Payload registers: hold until the next accepted item or result
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_ch.in_byte;
      s1_last_r <= in_ch.is_last;
    end
    if (s1_adv) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.kind           = out_res_r.kind;
  assign out_ch.msg_type       = out_res_r.msg_type;
  assign out_ch.msg_code       = out_res_r.msg_code;
  assign out_ch.msg_id         = out_res_r.msg_id;
  assign out_ch.token_len      = out_res_r.token_len;
  assign out_ch.option_number  = out_res_r.option_number;
  assign out_ch.option_length  = out_res_r.option_length;
  assign out_ch.data_byte      = out_res_r.data_byte;
  assign out_ch.end_of_message = out_res_r.end_of_message;
  assign out_ch.status         = out_res_r.status;

endmodule

>>> rtl/coapd_checker.sv
// Port-level checks on the CoAP message decoder result channel, bound to
// the top level. Depends on coapd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module coapd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_kind,
  input logic [15:0] out_option_number,
  input logic [16:0] out_option_length,
  input logic [7:0]  out_data_byte,
  input logic [2:0]  out_status
);
  import coapd_pkg::*;

  // Number and length appear only on an option start
  `COAPD_ASSERT(a_optnum_only_at_start, (out_valid && out_kind != KIND_OPT_START) |-> (out_option_number == '0 && out_option_length == '0), "option fields set outside option start")

  // Echoed byte only for token, option value and payload
  `COAPD_ASSERT(a_data_only_echo, (out_valid && out_kind != KIND_TOKEN && out_kind != KIND_OPT_VALUE && out_kind != KIND_PAYLOAD) |-> (out_data_byte == '0), "data byte set on a non-data item")

  // Ignored bytes occur only after an error
  `COAPD_ASSERT(a_ignored_has_error, (out_valid && out_kind == KIND_IGNORED) |-> (out_status != ST_OK), "ignored item without an error status")

  // A stalled result holds
  `COAPD_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_status) && $stable(out_data_byte), "result changed while stalled")

endmodule

bind coap_message_decoder coapd_checker u_coapd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_kind          (out_ch.kind),
  .out_option_number (out_ch.option_number),
  .out_option_length (out_ch.option_length),
  .out_data_byte     (out_ch.data_byte),
  .out_status        (out_ch.status)
);
